// ===== rtl/core/pss_pkg.sv =====
`timescale 1ns / 1ps

package pss_pkg;

    // Field widths of the stream payloads
    localparam int OP_W        = 4;
    localparam int POS_W       = 7;
    localparam int VALUE_W     = 32;
    localparam int FOUND_W     = 7;
    localparam int COUNT_W     = 7;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_ADDFRONT = 4'd0,
        OP_ADDREAR  = 4'd1,
        OP_INSERT   = 4'd2,
        OP_DELFRONT = 4'd3,
        OP_DELREAR  = 4'd4,
        OP_DELAT    = 4'd5,
        OP_READ     = 4'd6,
        OP_FIND     = 4'd7,
        OP_SWAP     = 4'd8,
        OP_CLEAR    = 4'd9
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2
    } t_status;

    localparam logic [FOUND_W-1:0] NOT_FOUND = '1;

    // Update command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del;
        logic swp;
    } t_cell_cmd;

endpackage

// ===== rtl/core/pss_cell.sv =====
`timescale 1ns / 1ps

module pss_cell import pss_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7,
    parameter int CMP_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [CMP_W-1:0]      i_tgt,
    input  logic [CMP_W-1:0]      i_pa,
    input  logic [CMP_W-1:0]      i_pb,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_swp_da,
    input  logic [DATA_WIDTH-1:0] i_swp_db,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic                  i_hit,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic [DATA_WIDTH-1:0] i_da,
    input  logic [DATA_WIDTH-1:0] i_db,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_hit,
    output logic [IDX_W-1:0]      o_idx,
    output logic [DATA_WIDTH-1:0] o_da,
    output logic [DATA_WIDTH-1:0] o_db
);

    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_hit;
    logic                  n_hit;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      n_idx;
    logic [DATA_WIDTH-1:0] r_da;
    logic [DATA_WIDTH-1:0] r_db;

    // Shift, insert or swap the held word
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (MY_POS > i_tgt) begin
                n_data = i_left;
            end else if (MY_POS == i_tgt) begin
                n_data = i_word;
            end
        end else if (i_cmd.del) begin
            if (MY_POS >= i_tgt) begin
                n_data = i_right;
            end
        end else if (i_cmd.swp) begin
            if (MY_POS == i_pa) begin
                n_data = i_swp_db;
            end else if (MY_POS == i_pb) begin
                n_data = i_swp_da;
            end
        end
    end

    // Mark the first live match on the passing token
    always_comb begin
        n_hit = i_hit;
        n_idx = i_idx;
        if (!i_hit && (MY_CNT < i_count) && (r_data == i_word)) begin
            n_hit = 1'b1;
            n_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hit  <= n_hit;
        r_idx  <= n_idx;
        r_da   <= (MY_POS == i_pa) ? r_data : i_da;
        r_db   <= (MY_POS == i_pb) ? r_data : i_db;
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;
    assign o_idx  = r_idx;
    assign o_da   = r_da;
    assign o_db   = r_db;

endmodule

// ===== rtl/core/positional_sequence_store.sv =====
`timescale 1ns / 1ps
// Ordered store of up to CAPACITY signed words with a fill count.
// Requests arrive on the s_axis channel: tuser carries the operation code,
// tdata the positions and the word. Each request gives exactly one result
// on the m_axis channel: read word, found index, count after the request
// and a status code.
// Add, insert, delete, clear and unknown codes: the request moves to the
// execute state and its result is loaded into the output register once
// the output is free; no new request is taken until the result is loaded.
// Read, find and swap: a token walks the row of cells one cell per cycle,
// and the result is loaded once the token has left the last cell and the
// output is free; no new request is taken before then.
// The output register decouples the sides: a new request is taken while
// a result still waits; the request then waits until the output is free.
// A stalled m_axis_tready therefore holds at most one finished result and
// one pending request.
// Reset clears the fill count and the handshake state; the stored words
// are not cleared, as no word past the count is ever read.
module positional_sequence_store import pss_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [6:0] position, [13:7] position_b, [45:14] value, [47:46] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [3:0] op
    input  logic [OP_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] read_value, [38:32] found_at, [45:39] count, [47:46] status
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } t_state;

    t_state                r_state;
    t_state                n_state;
    t_op                   r_op;
    logic [POS_W-1:0]      r_pa;
    logic [POS_W-1:0]      r_pb;
    logic [DATA_WIDTH-1:0] r_word;
    logic [IDX_W-1:0]      r_sweep;
    logic [IDX_W-1:0]      n_sweep;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_o_valid;
    logic                  n_o_valid;
    logic [VALUE_W-1:0]    r_o_read;
    logic [FOUND_W-1:0]    r_o_found;
    logic [COUNT_W-1:0]    r_o_count;
    t_status               r_o_status;

    logic                  w_accept;
    logic                  w_slot_free;
    logic                  w_apply;
    logic                  w_full;
    logic                  w_empty;
    logic [CMP_W-1:0]      w_pa_c;
    logic [CMP_W-1:0]      w_pb_c;
    logic [CMP_W-1:0]      w_cnt_c;
    t_cell_cmd             w_op_cmd;
    t_cell_cmd             w_cmd;
    logic [CMP_W-1:0]      w_tgt;
    logic [CNT_W-1:0]      w_res_count;
    t_status               w_res_status;
    logic [VALUE_W-1:0]    w_res_read;
    logic [FOUND_W-1:0]    w_res_found;

    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic                  w_hit  [CAPACITY+1];
    logic [IDX_W-1:0]      w_idx  [CAPACITY+1];
    logic [DATA_WIDTH-1:0] w_da   [CAPACITY+1];
    logic [DATA_WIDTH-1:0] w_db   [CAPACITY+1];

    // Handshake
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_o_valid || m_axis_tready;
    assign w_apply       = (r_state == S_EXEC) && w_slot_free;

    assign w_pa_c  = CMP_W'(r_pa);
    assign w_pb_c  = CMP_W'(r_pb);
    assign w_cnt_c = CMP_W'(r_count);
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    // Decode the held request against the count
    always_comb begin
        w_op_cmd     = '0;
        w_tgt        = '0;
        w_res_count  = r_count;
        w_res_status = STAT_DONE;
        w_res_read   = '0;
        w_res_found  = NOT_FOUND;
        case (r_op)
            OP_ADDFRONT, OP_ADDREAR: begin
                if (w_full) begin
                    w_res_status = STAT_FULL;
                end else begin
                    w_op_cmd.ins = 1'b1;
                    w_tgt        = (r_op == OP_ADDFRONT) ? '0 : w_cnt_c;
                    w_res_count  = r_count + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (w_pa_c > w_cnt_c) begin
                    w_res_status = STAT_IGNORED;
                end else if (w_full) begin
                    w_res_status = STAT_FULL;
                end else begin
                    w_op_cmd.ins = 1'b1;
                    w_tgt        = w_pa_c;
                    w_res_count  = r_count + CNT_W'(1);
                end
            end
            OP_DELFRONT, OP_DELREAR: begin
                if (w_empty) begin
                    w_res_status = STAT_IGNORED;
                end else begin
                    w_op_cmd.del = 1'b1;
                    w_tgt        = (r_op == OP_DELFRONT) ? '0 : w_cnt_c - CMP_W'(1);
                    w_res_count  = r_count - CNT_W'(1);
                end
            end
            OP_DELAT: begin
                if (w_pa_c >= w_cnt_c) begin
                    w_res_status = STAT_IGNORED;
                end else begin
                    w_op_cmd.del = 1'b1;
                    w_tgt        = w_pa_c;
                    w_res_count  = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (w_pa_c >= w_cnt_c) begin
                    w_res_status = STAT_IGNORED;
                end else begin
                    w_res_read = VALUE_W'($signed(w_da[CAPACITY]));
                end
            end
            OP_FIND: begin
                if (w_hit[CAPACITY]) begin
                    w_res_found = FOUND_W'(w_idx[CAPACITY]);
                end
            end
            OP_SWAP: begin
                if ((w_pa_c >= w_cnt_c) || (w_pb_c >= w_cnt_c)) begin
                    w_res_status = STAT_IGNORED;
                end else begin
                    w_op_cmd.swp = 1'b1;
                end
            end
            OP_CLEAR: begin
                w_res_count = '0;
            end
            default: begin
                w_res_status = STAT_IGNORED;
            end
        endcase
    end

    assign w_cmd = w_apply ? w_op_cmd : '0;

    // Sequence the request and the output register
    always_comb begin
        n_state   = r_state;
        n_sweep   = r_sweep;
        n_count   = w_apply ? w_res_count : r_count;
        n_o_valid = w_apply ? 1'b1 : (r_o_valid && !m_axis_tready);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sweep = IDX_W'(CAPACITY - 1);
                    if (s_axis_tuser inside {OP_READ, OP_FIND, OP_SWAP}) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SWEEP: begin
                if (r_sweep == '0) begin
                    n_state = S_EXEC;
                end else begin
                    n_sweep = r_sweep - IDX_W'(1);
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_sweep <= n_sweep;
        // Capture the request fields on transfer
        if (w_accept) begin
            r_op   <= t_op'(s_axis_tuser);
            r_pa   <= s_axis_tdata[POS_W-1:0];
            r_pb   <= s_axis_tdata[2*POS_W-1:POS_W];
            r_word <= DATA_WIDTH'($signed(s_axis_tdata[2*POS_W+VALUE_W-1:2*POS_W]));
        end
        // Load the result
        if (w_apply) begin
            r_o_read   <= w_res_read;
            r_o_found  <= w_res_found;
            r_o_count  <= COUNT_W'(w_res_count);
            r_o_status <= w_res_status;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_status, r_o_count, r_o_found, r_o_read};

    // Empty token enters the first cell
    assign w_hit[0] = 1'b0;
    assign w_idx[0] = '0;
    assign w_da[0]  = '0;
    assign w_db[0]  = '0;

    // Row of cells, one stored word each
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_data[g];
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end

        pss_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .CMP_W      (CMP_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_cmd    (w_cmd),
            .i_tgt    (w_tgt),
            .i_pa     (w_pa_c),
            .i_pb     (w_pb_c),
            .i_count  (r_count),
            .i_word   (r_word),
            .i_swp_da (w_da[CAPACITY]),
            .i_swp_db (w_db[CAPACITY]),
            .i_left   (w_left),
            .i_right  (w_right),
            .i_hit    (w_hit[g]),
            .i_idx    (w_idx[g]),
            .i_da     (w_da[g]),
            .i_db     (w_db[g]),
            .o_data   (w_data[g]),
            .o_hit    (w_hit[g+1]),
            .o_idx    (w_idx[g+1]),
            .o_da     (w_da[g+1]),
            .o_db     (w_db[g+1])
        );
    end

`ifndef SYNTH
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        ((r_count == $past(r_count) + CNT_W'(1)) ||
         (r_count == $past(r_count) - CNT_W'(1)) || (r_count == '0)))
        else $error("fill count moved by more than one");

    a_cells_in_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.ins || w_cmd.del || w_cmd.swp) |-> w_apply)
        else $error("cell update outside result load");

    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply |=> m_axis_tvalid)
        else $error("applied request gave no result");
`endif

endmodule

// ===== tb/pss_check_pkg.sv =====
`timescale 1ns / 1ps

package pss_check_pkg;
    import pss_pkg::*;

    localparam int STORE_DEPTH = 64;

    // Op codes past the last defined operation
    localparam logic [OP_W-1:0] OP_CODE_FIRST_UNUSED = 4'd10;
    localparam logic [OP_W-1:0] OP_CODE_LAST         = 4'd15;

    // One result, laid out as the m_axis tdata bits from the top down
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic [FOUND_W-1:0]  found_at;
        logic [VALUE_W-1:0]  read_value;
    } t_store_result;

    // Mirror of the stored sequence plus the results it still owes
    class store_mirror;
        logic [VALUE_W-1:0] words [STORE_DEPTH];
        int                 fill;
        t_store_result      awaited [$];
        int unsigned        results_seen;
        int unsigned        faults;

        function new();
            fill         = 0;
            results_seen = 0;
            faults       = 0;
        endfunction

        // Shift the tail up by one and drop the word into the gap
        function void open_gap(int at, logic [VALUE_W-1:0] word);
            int i;
            for (i = fill; i > at; i--) begin
                words[i] = words[i-1];
            end
            words[at] = word;
            fill++;
        endfunction

        // Shift the tail down over the removed slot
        function void close_gap(int at);
            int i;
            for (i = at; i + 1 < fill; i++) begin
                words[i] = words[i+1];
            end
            fill--;
        endfunction

        // Apply one accepted request and queue the result it must give
        function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pa,
                                   logic [POS_W-1:0] pb, logic [VALUE_W-1:0] word);
            t_store_result r;
            logic [VALUE_W-1:0] held;
            int i;
            r.read_value = '0;
            r.found_at   = NOT_FOUND;
            r.status     = STAT_DONE;
            case (op)
                OP_ADDFRONT, OP_ADDREAR: begin
                    if (fill >= STORE_DEPTH) r.status = STAT_FULL;
                    else open_gap((op == OP_ADDFRONT) ? 0 : fill, word);
                end
                OP_INSERT: begin
                    if (int'(pa) > fill) r.status = STAT_IGNORED;
                    else if (fill >= STORE_DEPTH) r.status = STAT_FULL;
                    else open_gap(int'(pa), word);
                end
                OP_DELFRONT, OP_DELREAR: begin
                    if (fill == 0) r.status = STAT_IGNORED;
                    else close_gap((op == OP_DELFRONT) ? 0 : fill - 1);
                end
                OP_DELAT: begin
                    if (int'(pa) >= fill) r.status = STAT_IGNORED;
                    else close_gap(int'(pa));
                end
                OP_READ: begin
                    if (int'(pa) >= fill) r.status = STAT_IGNORED;
                    else r.read_value = words[pa];
                end
                OP_FIND: begin
                    for (i = fill - 1; i >= 0; i--) begin
                        if (words[i] == word) r.found_at = FOUND_W'(i);
                    end
                end
                OP_SWAP: begin
                    if (int'(pa) >= fill || int'(pb) >= fill) begin
                        r.status = STAT_IGNORED;
                    end else begin
                        held      = words[pa];
                        words[pa] = words[pb];
                        words[pb] = held;
                    end
                end
                OP_CLEAR: fill = 0;
                default:  r.status = STAT_IGNORED;
            endcase
            r.count = COUNT_W'(fill);
            awaited.push_back(r);
        endfunction

        // Compare one result transfer with the oldest awaited result
        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            t_store_result got;
            t_store_result want;
            got = beat;
            results_seen++;
            if (awaited.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("result %0d arrived with none awaited: tdata=%h",
                             results_seen, beat);
                return;
            end
            want = awaited.pop_front();
            if (got.read_value !== want.read_value || got.found_at !== want.found_at ||
                got.count !== want.count || got.status !== want.status) begin
                faults++;
                if (faults <= 10)
                    $display({"result %0d mismatch: expected rd=%h found=%h count=%0d ",
                              "status=%0d, got rd=%h found=%h count=%0d status=%0d"},
                             results_seen, want.read_value, want.found_at, want.count,
                             want.status, got.read_value, got.found_at, got.count,
                             got.status);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

endpackage

// ===== tb/positional_sequence_store_test.sv =====
`timescale 1ns / 1ps

module positional_sequence_store_test;
    import pss_pkg::*;
    import pss_check_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 8;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} t_mix_mode;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]        s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic                   hold_off       = 1'b0;
    logic                   quiet_tail     = 1'b0;
    int                     items_accepted = 0;
    logic [VALUE_W-1:0]     word_pool [8];
    store_mirror            mirror = new();

    positional_sequence_store u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Offer one request and hold it until the transfer
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pa,
                                input logic [POS_W-1:0] pb, input logic [VALUE_W-1:0] word);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, word, pb, pa};
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.note_request(op, pa, pb, word);
        items_accepted <= items_accepted + 1;
    endtask

    // Weighted op choice; growth and shrink phases push the store to its bounds
    function automatic logic [OP_W-1:0] pick_op(t_mix_mode mode);
        t_op         order  [10];
        int unsigned weight [10];
        int unsigned roll;
        int          k;
        order = '{OP_ADDFRONT, OP_ADDREAR, OP_INSERT, OP_DELFRONT, OP_DELREAR,
                  OP_DELAT, OP_READ, OP_FIND, OP_SWAP, OP_CLEAR};
        case (mode)
            MODE_GROW:   weight = '{25, 25, 30, 1, 0, 0, 6, 6, 5, 0};
            MODE_SHRINK: weight = '{1, 1, 0, 20, 20, 30, 8, 8, 8, 2};
            default:     weight = '{10, 10, 12, 8, 8, 10, 14, 12, 10, 2};
        endcase
        roll = $urandom_range(0, 99);
        for (k = 0; k < 10; k++) begin
            if (roll < weight[k]) return order[k];
            roll -= weight[k];
        end
        // remaining share goes to the undefined codes
        return OP_W'($urandom_range(OP_CODE_FIRST_UNUSED, OP_CODE_LAST));
    endfunction

    // Mostly in range up to top, now and then anywhere in the field
    function automatic logic [POS_W-1:0] pick_pos(int top);
        if (top < 0 || $urandom_range(0, 99) < 12) return POS_W'($urandom_range(0, 127));
        return POS_W'($urandom_range(0, top));
    endfunction

    // Pool words repeat so that finds hit; extremes and free words fill the rest
    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return word_pool[$urandom_range(0, 7)];
            5: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Directed opening: empty store, bounds of positions and words, every op
    task automatic run_directed();
        send_request(OP_DELFRONT, 7'd0, 7'd0, 32'h0);
        send_request(OP_DELREAR, 7'd0, 7'd0, 32'h0);
        send_request(OP_DELAT, 7'd0, 7'd0, 32'h0);
        send_request(OP_READ, 7'd0, 7'd0, 32'h0);
        send_request(OP_FIND, 7'd0, 7'd0, 32'h0);
        send_request(OP_SWAP, 7'd0, 7'd0, 32'h0);
        send_request(OP_CLEAR, 7'd0, 7'd0, 32'h0);
        send_request(OP_ADDREAR, 7'd0, 7'd0, 32'h7FFF_FFFF);
        send_request(OP_ADDFRONT, 7'd0, 7'd0, 32'h8000_0000);
        send_request(OP_INSERT, 7'd1, 7'd0, 32'h0000_0000);
        // insert at the count appends
        send_request(OP_INSERT, 7'd3, 7'd0, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 7'd5, 7'd0, 32'h1234_5678);
        send_request(OP_READ, 7'd0, 7'd0, 32'h0);
        send_request(OP_READ, 7'd3, 7'd0, 32'h0);
        send_request(OP_READ, 7'd4, 7'd0, 32'h0);
        send_request(OP_READ, 7'd127, 7'd127, 32'h0);
        send_request(OP_FIND, 7'd0, 7'd0, 32'hFFFF_FFFF);
        send_request(OP_FIND, 7'd0, 7'd0, 32'h0000_1234);
        send_request(OP_SWAP, 7'd0, 7'd3, 32'h0);
        send_request(OP_SWAP, 7'd1, 7'd1, 32'h0);
        send_request(OP_SWAP, 7'd0, 7'd4, 32'h0);
        send_request(OP_DELAT, 7'd1, 7'd0, 32'h0);
        send_request(OP_DELAT, 7'd64, 7'd0, 32'h0);
        send_request(OP_DELREAR, 7'd0, 7'd0, 32'h0);
        send_request(OP_CODE_FIRST_UNUSED, 7'd0, 7'd0, 32'h0);
        send_request(OP_CODE_LAST, 7'h7F, 7'h7F, 32'hFFFF_FFFF);
        send_request(OP_CLEAR, 7'd0, 7'd0, 32'h0);
    endtask

    // Request side: reset, directed part, random phases, drain and verdict
    initial begin : request_source
        t_mix_mode        mode;
        int               seg_left;
        bit               idle_on;
        int               n;
        int               k;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pa;
        logic [POS_W-1:0] pb;
        mode     = MODE_MIX;
        seg_left = 0;
        idle_on  = 1'b0;
        for (k = 0; k < 8; k++) word_pool[k] = $urandom();
        word_pool[0] = 32'h8000_0000;
        word_pool[1] = 32'h7FFF_FFFF;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(30, 90);
                mode     = t_mix_mode'($urandom_range(0, 2));
                idle_on  = $urandom_range(0, 2) != 0;
            end
            seg_left--;
            if (n == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail <= 1'b1;
            // idle burst on the request side
            if (idle_on && n < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            op = pick_op(mode);
            pa = POS_W'($urandom_range(0, 127));
            pb = POS_W'($urandom_range(0, 127));
            case (op)
                OP_INSERT:        pa = pick_pos(mirror.fill);
                OP_DELAT, OP_READ: pa = pick_pos(mirror.fill - 1);
                OP_SWAP: begin
                    pa = pick_pos(mirror.fill - 1);
                    pb = pick_pos(mirror.fill - 1);
                end
                default: ;
            endcase
            send_request(op, pa, pb, pick_word());
        end
        s_axis_tvalid <= 1'b0;

        // wait for every owed result, then a little longer for strays
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mirror.faults == 0 && mirror.pending() == 0) begin
            $display("positional_sequence_store_test OK");
        end else begin
            $display("positional_sequence_store_test NOT OK");
        end
        $finish;
    end

    // Result side: check each transfer, stall in bursts during busy phases
    initial begin : result_sink
        int stall_left;
        int phase_left;
        bit busy;
        stall_left = 0;
        phase_left = 0;
        busy       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) mirror.check_result(m_axis_tdata);
            if (phase_left == 0) begin
                phase_left = $urandom_range(50, 400);
                busy       = $urandom_range(0, 2) != 0;
            end else begin
                phase_left--;
            end
            if (stall_left > 0) stall_left--;
            else if (busy && !quiet_tail && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 19);
            m_axis_tready <= !(hold_off || stall_left > 0);
        end
    end

    // Hold the result side off for a long stretch so the input backs up
    initial begin : long_hold
        wait (items_accepted >= HOLD_AT);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        #(10_000_000);
        $display("positional_sequence_store_test NOT OK");
        $finish;
    end

endmodule
